/* sv/spas_pkg.sv */
// Package for the sliding piece attack set block: command codes, board
// constants and the ray direction tables.
// No dependencies.
package spas_pkg;

    // Command codes
    localparam logic [1:0] CMD_ROOK_ATTACKS   = 2'd0;
    localparam logic [1:0] CMD_BISHOP_ATTACKS = 2'd1;
    localparam logic [1:0] CMD_ROOK_MASK      = 2'd2;
    localparam logic [1:0] CMD_BISHOP_MASK    = 2'd3;

    // Signed board coordinate, wide enough for a ray that runs off the board
    typedef logic signed [4:0] coord_t;

    typedef logic [63:0] bitboard_t;

    localparam coord_t EDGE_LOW   = 5'sd0;
    localparam coord_t EDGE_HIGH  = 5'sd7;
    localparam coord_t INNER_LOW  = 5'sd1;
    localparam coord_t INNER_HIGH = 5'sd6;

    localparam int NUM_DIRS  = 4;
    localparam int MAX_STEPS = 7;

    // Rank and file steps of the four rays, orthogonal and diagonal
    localparam coord_t ORTHO_DR [NUM_DIRS] = '{5'sd1, -5'sd1, 5'sd0, 5'sd0};
    localparam coord_t ORTHO_DF [NUM_DIRS] = '{5'sd0, 5'sd0, 5'sd1, -5'sd1};
    localparam coord_t DIAG_DR  [NUM_DIRS] = '{5'sd1, 5'sd1, -5'sd1, -5'sd1};
    localparam coord_t DIAG_DF  [NUM_DIRS] = '{5'sd1, -5'sd1, 5'sd1, -5'sd1};

endpackage

/* sv/spas_if.sv */
// Handshake interfaces for the query and result channels.
// Depends on spas_pkg for the payload types.
interface spas_query_if
    import spas_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [5:0] square;
    bitboard_t  blockers;

    modport source (output valid, output command, output square, output blockers,
                    input ready);
    modport sink   (input valid, input command, input square, input blockers,
                    output ready);
endinterface

interface spas_result_if
    import spas_pkg::*;
();
    logic      valid;
    logic      ready;
    bitboard_t attack_set;

    modport source (output valid, output attack_set, input ready);
    modport sink   (input valid, input attack_set, output ready);
endinterface

/* sv/spas_ray_gen.sv */
// Combinational ray generator: four rays from the origin square, each
// stopping after the first blocker, or before the edge for mask commands.
// Depends on spas_pkg.
module spas_ray_gen
    import spas_pkg::*;
(
    input  logic [1:0] command,
    input  logic [5:0] square,
    input  bitboard_t  blockers,
    output bitboard_t  attack_set
);

    logic      diagonal;
    logic      mask_mode;
    coord_t    lo;
    coord_t    hi;
    bitboard_t occ;

    // Decode the command
    assign diagonal  = (command == CMD_BISHOP_ATTACKS) || (command == CMD_BISHOP_MASK);
    assign mask_mode = (command == CMD_ROOK_MASK) || (command == CMD_BISHOP_MASK);
    assign lo        = mask_mode ? INNER_LOW : EDGE_LOW;
    assign hi        = mask_mode ? INNER_HIGH : EDGE_HIGH;
    assign occ       = mask_mode ? '0 : blockers;

    // Walk each ray outward; live drops once the ray leaves its bounds or marks a blocker
    always_comb
    begin
        coord_t    r;
        coord_t    f;
        coord_t    dr;
        coord_t    df;
        logic      live;
        logic [5:0] idx;
        bitboard_t acc;

        acc = '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            dr   = diagonal ? DIAG_DR[d] : ORTHO_DR[d];
            df   = diagonal ? DIAG_DF[d] : ORTHO_DF[d];
            r    = {2'b00, square[5:3]};
            f    = {2'b00, square[2:0]};
            live = 1'b1;
            for (int k = 0; k < MAX_STEPS; k++)
            begin
                r = r + dr;
                f = f + df;
                if ((dr != 5'sd0) && ((r < lo) || (r > hi)))
                    live = 1'b0;
                if ((df != 5'sd0) && ((f < lo) || (f > hi)))
                    live = 1'b0;
                if ((r < EDGE_LOW) || (r > EDGE_HIGH) || (f < EDGE_LOW) || (f > EDGE_HIGH))
                    live = 1'b0;
                idx = {r[2:0], f[2:0]};
                if (live)
                begin
                    acc[idx] = 1'b1;
                    if (occ[idx])
                        live = 1'b0;
                end
            end
        end
        attack_set = acc;
    end

endmodule

/* sv/sliding_piece_attack_sets.sv */
// Top level of the sliding piece attack set block: input register, ray
// generator and result register with valid/ready flow control.
// Depends on spas_pkg, spas_if and spas_ray_gen.
//
// Usage:
//   query  : sink channel carrying command, square and blockers.
//   result : source channel carrying the 64-bit attack_set.
//   One result per query transaction, in order.
//   A query waits in the input register until the result register is empty
//   or being drained, then moves there and holds result.valid until taken.
//   One query per cycle while the result channel is not stalled; the ray
//   generator between the registers is combinational over the 8x8 board.
//   query.ready stays high while the result register is empty or being
//   drained, so a new query is taken while an older result waits.
//   Reset clears both valid flags; no query or result is held afterward.
//   When the receiver stalls, the result stays stable, the input register
//   holds one more query and query.ready then drops.
module sliding_piece_attack_sets
    import spas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    spas_query_if.sink        query,
    spas_result_if.source     result
);

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [1:0] s1_command_reg;
    logic [5:0] s1_square_reg;
    bitboard_t  s1_blockers_reg;
    logic       s2_valid_reg;
    logic       s2_valid_next;
    bitboard_t  s2_attack_reg;
    bitboard_t  ray_set;
    logic       s1_advance;
    logic       in_take;

    // Flow control
    assign s1_advance  = !s2_valid_reg || result.ready;
    assign query.ready = !s1_valid_reg || s1_advance;
    assign in_take     = query.valid && query.ready;

    assign s1_valid_next = in_take || (s1_valid_reg && !s1_advance);
    assign s2_valid_next = (s1_valid_reg && s1_advance) || (s2_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_command_reg  <= query.command;
            s1_square_reg   <= query.square;
            s1_blockers_reg <= query.blockers;
        end
    end

    // Ray generation
    spas_ray_gen u_ray_gen (
        .command    (s1_command_reg),
        .square     (s1_square_reg),
        .blockers   (s1_blockers_reg),
        .attack_set (ray_set)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_advance)
            s2_attack_reg <= ray_set;
    end

    assign result.valid      = s2_valid_reg;
    assign result.attack_set = s2_attack_reg;

endmodule

/* sv/spas_checker.sv */
// Port-level checker for sliding_piece_attack_sets and its bind.
// Depends on spas_pkg.
module spas_checker
    import spas_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input bitboard_t attack_set
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(attack_set))
        else $error("result changed while stalled");

    // An accepted query reaches the output through both registers with no stall
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid)
        else $error("accepted query lost or late");

    // With the result register empty the block always takes a query
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("query stalled with empty output");

endmodule

bind sliding_piece_attack_sets spas_checker u_spas_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .attack_set (result.attack_set)
);
